// ----- rtl/core/tps_pkg.sv -----
// shared types and constants of the time-slice priority scheduler
package tps_pkg;

    localparam int TPS_TASK_COUNT = 8;
    localparam int TPS_TASK_W     = 3;
    localparam int TPS_CNT_W      = 8;
    localparam int TPS_PRIO_W     = 7;
    localparam int TPS_PRIO_NUM   = 7;
    localparam int TPS_CFG_IDX_W  = 3;
    localparam int TPS_S_DATA_W   = 16;
    localparam int TPS_M_DATA_W   = 16;

    localparam logic TPS_CMD_TICK = 1'b0;
    localparam logic TPS_CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        ALU_PASS   = 2'd0,
        ALU_DEC    = 2'd1,
        ALU_REFILL = 2'd2
    } alu_op_t;

endpackage

// ----- rtl/core/tps_slice_alu.sv -----
// shared counter unit: decrement, refill and compare against the best counter
module tps_slice_alu
    import tps_pkg::*;
(
    input  alu_op_t                 op,
    input  logic [TPS_CNT_W-1:0]    operand,
    input  logic [TPS_CNT_W-1:0]    best_cnt,
    input  logic [TPS_PRIO_W-1:0]   prio,
    output logic [TPS_CNT_W-1:0]    result,
    output logic                    result_zero,
    output logic                    greater
);

    logic [TPS_CNT_W:0] refill_sum;

    assign refill_sum = {1'b0, operand >> 1} + {2'b00, prio};

    always_comb begin
        case (op)
            ALU_DEC: begin
                result = (operand != '0) ? operand - TPS_CNT_W'(1) : '0;
            end
            ALU_REFILL: begin
                result = refill_sum[TPS_CNT_W] ? '1 : refill_sum[TPS_CNT_W-1:0];
            end
            default: begin
                result = operand;
            end
        endcase
    end

    assign result_zero = (result == '0);
    assign greater     = (operand > best_cnt);

endmodule

// ----- rtl/core/tps_counter_file.sv -----
// per-task time-slice counters, one write and one read port
module tps_counter_file
    import tps_pkg::*;
#(
    parameter int TASK_COUNT = TPS_TASK_COUNT,
    parameter int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [TPS_CNT_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [TPS_CNT_W-1:0]  rd_data
);

    logic [TPS_CNT_W-1:0] cnt_reg [TASK_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TASK_COUNT; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (wr_en) begin
            cnt_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = cnt_reg[rd_addr];

endmodule

// ----- rtl/core/timeslice_priority_scheduler_unit.sv -----
// Time-slice priority scheduler top level. Each request is a timer tick (tuser 0) or a load
// of one task's slice counter (tuser 1) and yields one result. A tick walks the counters
// through one shared counter unit, one task per cycle: a decrement of the running task's
// counter, a scan of tasks TASK_COUNT-1 down to 1, and when all counters are zero a refill
// of tasks 1 to TASK_COUNT-1 and a second scan. The block takes one request at a time; a
// finished result waits in the output register while the next request is accepted.
module timeslice_priority_scheduler_unit
    import tps_pkg::*;
#(
    parameter int TASK_COUNT = TPS_TASK_COUNT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // task_index [2:0], counter_value [10:3], zero fill
    input  logic [TPS_S_DATA_W-1:0]   s_tdata,
    // command [0]
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // running_task [2:0], switched [3], running_counter [11:4], refilled [12],
    // stalled [13], zero fill
    output logic [TPS_M_DATA_W-1:0]   m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [TPS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [TPS_PRIO_W-1:0]     cfg_wdata
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
    localparam logic [TPS_TASK_W:0] TASK_LIMIT = (TPS_TASK_W + 1)'(TASK_COUNT);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DEC    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_REFILL = 5'b01000,
        ST_REPORT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      before_reg, before_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [TPS_CNT_W-1:0]  bestc_reg, bestc_next;
    logic                  refilled_reg, refilled_next;
    logic                  stalled_reg, stalled_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TPS_TASK_W-1:0] out_task_reg;
    logic                  out_sw_reg;
    logic [TPS_CNT_W-1:0]  out_cnt_reg;
    logic                  out_refill_reg;
    logic                  out_stall_reg;
    logic                  out_load;

    logic [TPS_PRIO_W-1:0] prio_reg [TPS_PRIO_NUM];

    logic                  cf_wr_en;
    logic [IDX_W-1:0]      cf_wr_addr;
    logic [TPS_CNT_W-1:0]  cf_wr_data;
    logic [IDX_W-1:0]      cf_rd_addr;
    logic [TPS_CNT_W-1:0]  cf_rd_data;

    alu_op_t               alu_op;
    logic [TPS_CNT_W-1:0]  alu_result;
    logic                  alu_zero;
    logic                  alu_gt;
    logic [TPS_CFG_IDX_W-1:0] prio_idx;
    logic [TPS_PRIO_W-1:0] prio_sel;

    logic [TPS_TASK_W-1:0] in_task;
    logic [TPS_CNT_W-1:0]  in_value;
    logic                  load_ok;
    logic [IDX_W-1:0]      best_fin;

    assign in_task  = s_tdata[TPS_TASK_W-1:0];
    assign in_value = s_tdata[TPS_TASK_W+TPS_CNT_W-1:TPS_TASK_W];
    assign load_ok  = (in_task != '0) && ({1'b0, in_task} < TASK_LIMIT);

    // priority registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TPS_PRIO_NUM; k++) begin
                prio_reg[k] <= TPS_PRIO_W'(1);
            end
        end else if (cfg_wr_en && (cfg_index < TPS_CFG_IDX_W'(TPS_PRIO_NUM))) begin
            prio_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign prio_idx = TPS_CFG_IDX_W'(idx_reg) - TPS_CFG_IDX_W'(1);
    assign prio_sel = (prio_idx < TPS_CFG_IDX_W'(TPS_PRIO_NUM)) ? prio_reg[prio_idx] : '0;

    tps_counter_file #(
        .TASK_COUNT (TASK_COUNT),
        .IDX_W      (IDX_W)
    ) u_counters (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cf_wr_en),
        .wr_addr (cf_wr_addr),
        .wr_data (cf_wr_data),
        .rd_addr (cf_rd_addr),
        .rd_data (cf_rd_data)
    );

    tps_slice_alu u_alu (
        .op          (alu_op),
        .operand     (cf_rd_data),
        .best_cnt    (bestc_reg),
        .prio        (prio_sel),
        .result      (alu_result),
        .result_zero (alu_zero),
        .greater     (alu_gt)
    );

    assign best_fin = alu_gt ? idx_reg : best_reg;

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        before_next   = before_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        bestc_next    = bestc_reg;
        refilled_next = refilled_reg;
        stalled_next  = stalled_reg;
        s_tready      = 1'b0;
        cf_wr_en      = 1'b0;
        cf_wr_addr    = cur_reg;
        cf_wr_data    = alu_result;
        cf_rd_addr    = cur_reg;
        alu_op        = ALU_PASS;
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    before_next   = cur_reg;
                    refilled_next = 1'b0;
                    stalled_next  = 1'b0;
                    if (s_tuser == TPS_CMD_LOAD) begin
                        cf_wr_en   = load_ok;
                        cf_wr_addr = in_task[IDX_W-1:0];
                        cf_wr_data = in_value;
                        state_next = ST_REPORT;
                    end else if (cur_reg == '0) begin
                        idx_next   = LAST_IDX;
                        best_next  = '0;
                        bestc_next = '0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC: begin
                alu_op   = ALU_DEC;
                cf_wr_en = 1'b1;
                if (alu_zero) begin
                    idx_next   = LAST_IDX;
                    best_next  = '0;
                    bestc_next = '0;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_SCAN: begin
                cf_rd_addr = idx_reg;
                if (alu_gt) begin
                    best_next  = idx_reg;
                    bestc_next = cf_rd_data;
                end
                if (idx_reg == FIRST_IDX) begin
                    if (best_fin != '0) begin
                        cur_next   = best_fin;
                        state_next = ST_REPORT;
                    end else if (!refilled_reg) begin
                        refilled_next = 1'b1;
                        idx_next      = FIRST_IDX;
                        state_next    = ST_REFILL;
                    end else begin
                        stalled_next = 1'b1;
                        state_next   = ST_REPORT;
                    end
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_REFILL: begin
                cf_rd_addr = idx_reg;
                cf_wr_addr = idx_reg;
                alu_op     = ALU_REFILL;
                cf_wr_en   = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = LAST_IDX;
                    best_next  = '0;
                    bestc_next = '0;
                    state_next = ST_SCAN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_REPORT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            before_reg   <= '0;
            idx_reg      <= '0;
            best_reg     <= '0;
            bestc_reg    <= '0;
            refilled_reg <= 1'b0;
            stalled_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            before_reg   <= before_next;
            idx_reg      <= idx_next;
            best_reg     <= best_next;
            bestc_reg    <= bestc_next;
            refilled_reg <= refilled_next;
            stalled_reg  <= stalled_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_task_reg   <= TPS_TASK_W'(cur_reg);
            out_sw_reg     <= (cur_reg != before_reg);
            out_cnt_reg    <= cf_rd_data;
            out_refill_reg <= refilled_reg;
            out_stall_reg  <= stalled_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_stall_reg, out_refill_reg, out_cnt_reg, out_sw_reg,
                       out_task_reg};

endmodule

// ----- rtl/core/tps_checker.sv -----
// port-level checks of the scheduler, bound to the top level
module tps_checker
    import tps_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [TPS_M_DATA_W-1:0]   m_tdata
);

    // a stall only follows a refill
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[13] || m_tdata[12]))
        else $error("stalled without refill");

    // a switch never lands on the idle task and never comes with a stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> ((m_tdata[2:0] != 3'd0) && !m_tdata[13]))
        else $error("bad switch result");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // no result right out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind timeslice_priority_scheduler_unit tps_checker u_tps_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the time-slice priority scheduler with random idling on both sides
module testbench;
    import tps_pkg::*;

    typedef struct packed {
        logic                  command;
        logic [TPS_TASK_W-1:0] task_index;
        logic [TPS_CNT_W-1:0]  counter_value;
    } sched_req_t;

    typedef struct packed {
        logic [TPS_TASK_W-1:0] running_task;
        logic                  switched;
        logic [TPS_CNT_W-1:0]  running_counter;
        logic                  refilled;
        logic                  stalled;
    } sched_res_t;

    typedef enum int {
        PRIO_RANDOM,
        PRIO_MAX,
        PRIO_ZERO,
        PRIO_SPARSE,
        PRIO_ONE
    } prio_mode_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 3 * (TPS_TASK_COUNT - 1) + 10;
    localparam int PHASE_ITEMS    = 250;
    localparam int PHASE_NUM      = 6;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [TPS_S_DATA_W-1:0]  s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [TPS_M_DATA_W-1:0]  m_tdata;
    logic                     cfg_wr_en = 1'b0;
    logic [TPS_CFG_IDX_W-1:0] cfg_index = '0;
    logic [TPS_PRIO_W-1:0]    cfg_wdata = '0;

    sched_req_t request_q[$];
    sched_res_t sched_out_q[$];

    // predictor state
    logic [TPS_CNT_W-1:0]  slice_cnt [TPS_TASK_COUNT];
    logic [TPS_PRIO_W-1:0] task_prio [TPS_TASK_COUNT];
    logic [TPS_TASK_W-1:0] cur_task;

    int         error_count  = 0;
    int         quiet_cycles = 0;
    int         s_gap        = 0;
    int         m_gap        = 0;
    bit         s_calm       = 1'b0;
    bit         m_calm       = 1'b0;
    sched_req_t drive_req;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    timeslice_priority_scheduler_unit #(
        .TASK_COUNT(TPS_TASK_COUNT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic logic [TPS_TASK_W-1:0] scan_counters();
        logic [TPS_TASK_W-1:0] best;
        logic [TPS_CNT_W-1:0]  best_cnt;
        best     = '0;
        best_cnt = '0;
        for (int t = TPS_TASK_COUNT - 1; t >= 1; t--) begin
            if (slice_cnt[t] > best_cnt) begin
                best_cnt = slice_cnt[t];
                best     = t[TPS_TASK_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic void pick_next_task(output logic refilled, output logic stalled);
        logic [TPS_TASK_W-1:0] pick;
        logic [TPS_CNT_W:0]    sum;
        refilled = 1'b0;
        stalled  = 1'b0;
        pick     = scan_counters();
        if (pick == '0) begin
            for (int t = 1; t < TPS_TASK_COUNT; t++) begin
                sum          = (slice_cnt[t] >> 1) + task_prio[t];
                slice_cnt[t] = (sum > 255) ? 8'd255 : sum[TPS_CNT_W-1:0];
            end
            refilled = 1'b1;
            pick     = scan_counters();
        end
        if (pick == '0) begin
            stalled = 1'b1;
        end else begin
            cur_task = pick;
        end
    endfunction

    function automatic sched_res_t predict_schedule(input sched_req_t req);
        sched_res_t            res;
        logic [TPS_TASK_W-1:0] prev;
        logic                  refilled;
        logic                  stalled;
        prev     = cur_task;
        refilled = 1'b0;
        stalled  = 1'b0;
        if (req.command == TPS_CMD_LOAD) begin
            if (req.task_index != '0 && req.task_index < TPS_TASK_COUNT) begin
                slice_cnt[req.task_index] = req.counter_value;
            end
        end else if (prev == '0) begin
            pick_next_task(refilled, stalled);
        end else begin
            if (slice_cnt[prev] != '0) begin
                slice_cnt[prev] = slice_cnt[prev] - 1'b1;
            end
            if (slice_cnt[prev] == '0) begin
                pick_next_task(refilled, stalled);
            end
        end
        res.running_task    = cur_task;
        res.switched        = (cur_task != prev);
        res.running_counter = slice_cnt[cur_task];
        res.refilled        = refilled;
        res.stalled         = stalled;
        return res;
    endfunction

    task automatic queue_req(input logic command, input int idx, input int value);
        sched_req_t req;
        req.command       = command;
        req.task_index    = idx[TPS_TASK_W-1:0];
        req.counter_value = value[TPS_CNT_W-1:0];
        request_q.push_back(req);
    endtask

    task automatic write_prio(input int idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[TPS_CFG_IDX_W-1:0];
        cfg_wdata <= value[TPS_PRIO_W-1:0];
        if (idx < TPS_PRIO_NUM) begin
            task_prio[idx + 1] = value[TPS_PRIO_W-1:0];
        end
    endtask

    task automatic program_priorities(input prio_mode_t mode);
        int value;
        for (int i = 0; i < TPS_PRIO_NUM; i++) begin
            case (mode)
                PRIO_MAX:    value = 127;
                PRIO_ZERO:   value = 0;
                PRIO_ONE:    value = 1;
                PRIO_SPARSE: value = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 127) : 0;
                default:     value = $urandom_range(0, 127);
            endcase
            write_prio(i, value);
        end
        // unused index, must not disturb anything
        if ($urandom_range(0, 1) == 1) begin
            write_prio(TPS_PRIO_NUM, $urandom_range(0, 127));
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (request_q.size() != 0 || s_tvalid || sched_out_q.size() != 0);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                sched_out_q.push_back(predict_schedule(drive_req));
            end
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                drive_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drive_req.command;
                s_tdata  <= TPS_S_DATA_W'({drive_req.counter_value, drive_req.task_index});
                if ($urandom_range(0, 31) == 0) begin
                    s_calm = !s_calm;
                end
                s_gap = s_calm ? 0 : $urandom_range(0, 6);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        sched_res_t got;
        sched_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.running_task    = m_tdata[2:0];
                got.switched        = m_tdata[3];
                got.running_counter = m_tdata[11:4];
                got.refilled        = m_tdata[12];
                got.stalled         = m_tdata[13];
                if (sched_out_q.size() == 0) begin
                    report_error($sformatf("result with nothing expected: %h", m_tdata));
                end else begin
                    want = sched_out_q.pop_front();
                    if (got.running_task != want.running_task)
                        report_error($sformatf("running_task got %0d expected %0d",
                            got.running_task, want.running_task));
                    if (got.switched != want.switched)
                        report_error($sformatf("switched got %0d expected %0d",
                            got.switched, want.switched));
                    if (got.running_counter != want.running_counter)
                        report_error($sformatf("running_counter got %0d expected %0d",
                            got.running_counter, want.running_counter));
                    if (got.refilled != want.refilled)
                        report_error($sformatf("refilled got %0d expected %0d",
                            got.refilled, want.refilled));
                    if (got.stalled != want.stalled)
                        report_error($sformatf("stalled got %0d expected %0d",
                            got.stalled, want.stalled));
                end
                if ($urandom_range(0, 31) == 0) begin
                    m_calm = !m_calm;
                end
                m_gap = m_calm ? 0 : $urandom_range(0, 6);
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        prio_mode_t phase_modes [PHASE_NUM];
        int         roll;
        phase_modes = '{PRIO_RANDOM, PRIO_MAX, PRIO_SPARSE, PRIO_ONE, PRIO_ZERO, PRIO_RANDOM};
        for (int t = 0; t < TPS_TASK_COUNT; t++) begin
            slice_cnt[t] = '0;
            task_prio[t] = (t == 0) ? '0 : 7'd1;
        end
        cur_task = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle task ticks with every counter zero, then loads and switches
        queue_req(TPS_CMD_TICK, 0, 0);
        queue_req(TPS_CMD_LOAD, 0, 255);
        queue_req(TPS_CMD_LOAD, 7, 255);
        queue_req(TPS_CMD_LOAD, 3, 200);
        queue_req(TPS_CMD_LOAD, 5, 8'h55);
        queue_req(TPS_CMD_LOAD, 6, 8'hAA);
        queue_req(TPS_CMD_TICK, 0, 0);
        queue_req(TPS_CMD_LOAD, 7, 1);
        queue_req(TPS_CMD_TICK, 7, 255);
        queue_req(TPS_CMD_LOAD, 3, 0);
        queue_req(TPS_CMD_TICK, 0, 0);
        queue_req(TPS_CMD_TICK, 0, 0);
        wait_idle();

        // all priorities zero: stall keeps the running task
        program_priorities(PRIO_ZERO);
        for (int t = 1; t < TPS_TASK_COUNT; t++) begin
            queue_req(TPS_CMD_LOAD, t, 0);
        end
        queue_req(TPS_CMD_TICK, 0, 0);
        queue_req(TPS_CMD_TICK, 0, 0);
        wait_idle();

        for (int p = 0; p < PHASE_NUM; p++) begin
            program_priorities(phase_modes[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 30) begin
                    queue_req(TPS_CMD_LOAD, $urandom_range(1, TPS_TASK_COUNT - 1),
                        ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6)
                                                    : $urandom_range(0, 255));
                end else if (roll < 33) begin
                    queue_req(TPS_CMD_LOAD, 0, $urandom_range(0, 255));
                end else begin
                    queue_req(TPS_CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 255));
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sched_out_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", sched_out_q.size()));
        end
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
